// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// Clocked on clk_i and disabled while rst_ni is low; ASSERT_OFF removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- design/pngu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
// No dependencies.
`timescale 1ns / 1ps

package pngu_pkg;

  localparam int unsigned DEF_MAX_ROW_BYTES = 4096;
  localparam int unsigned CFG_W             = 13;

  localparam logic REG_BYTES_PER_ROW   = 1'b0;
  localparam logic REG_BYTES_PER_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

endpackage

// ----- design/pngu_predict.sv -----
// Predictor and reconstruction adder for one pixel byte.
// Depends on pngu_pkg for the filter type codes.
`timescale 1ns / 1ps

module pngu_predict
  import pngu_pkg::*;
(
  input  filter_e    filt_i,
  input  logic [7:0] left_i,
  input  logic [7:0] above_i,
  input  logic [7:0] upleft_i,
  input  logic [7:0] data_i,
  output logic [7:0] pixel_o
);

  logic [8:0]        sum_ab;
  logic signed [9:0] diff_bc, diff_ac, diff_p;
  logic [9:0]        pa, pb, pc;
  logic [7:0]        paeth, pred;

  assign sum_ab  = {1'b0, left_i} + {1'b0, above_i};
  assign diff_bc = $signed({2'b00, above_i}) - $signed({2'b00, upleft_i});
  assign diff_ac = $signed({2'b00, left_i}) - $signed({2'b00, upleft_i});
  assign diff_p  = $signed({1'b0, sum_ab}) - $signed({1'b0, upleft_i, 1'b0});

  assign pa = diff_bc[9] ? 10'(-diff_bc) : 10'(diff_bc);
  assign pb = diff_ac[9] ? 10'(-diff_ac) : 10'(diff_ac);
  assign pc = diff_p[9]  ? 10'(-diff_p)  : 10'(diff_p);

  // Ties go to left, then above.
  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth = left_i;
    end else if (pb <= pc) begin
      paeth = above_i;
    end else begin
      paeth = upleft_i;
    end
  end

  always_comb begin
    unique case (filt_i)
      FILT_SUB:   pred = left_i;
      FILT_UP:    pred = above_i;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign pixel_o = data_i + pred;

endmodule

// ----- design/png_scanline_unfilter.sv -----
// PNG scanline unfilter: takes one inflated byte per beat and returns one
// reconstructed byte per pixel byte (none for the filter byte that opens each
// row). It accepts a byte every cycle while the output is not stalled; a
// byte's result goes through the work stage into the output register. The
// rate is set by the above-row RAM, a simple dual-port memory that is read
// once per byte at acceptance and written once per pixel byte when its
// result is formed. A pixel beat held by a stalled output holds the input.
// Depends on pngu_pkg, pngu_predict and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module png_scanline_unfilter
  import pngu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             image_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       pixel_byte_o,
  output logic             row_end_o
);

  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned LW = (PW > CFG_W) ? PW : CFG_W;

  // Configuration
  logic [CFG_W-1:0] bpr_q;
  logic [2:0]       bpp_q;
  logic [LW-1:0]    len_eff;
  logic [1:0]       dist_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q <= CFG_W'(1);
      bpp_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BYTES_PER_ROW:   bpr_q <= cfg_wdata_i;
        REG_BYTES_PER_PIXEL: bpp_q <= cfg_wdata_i[2:0];
        default:             bpr_q <= bpr_q;
      endcase
    end
  end

  always_comb begin
    if (bpr_q == '0) begin
      len_eff = LW'(1);
    end else if (LW'(bpr_q) > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = LW'(bpr_q);
    end
  end

  always_comb begin
    if (bpp_q == 3'd0) begin
      dist_sel = 2'd0;
    end else if (bpp_q > 3'd4) begin
      dist_sel = 2'd3;
    end else begin
      dist_sel = 2'(bpp_q - 3'd1);
    end
  end

  // Front end: row position, filter type and first-row flag, tracked on accept
  logic          in_acc, row_last;
  logic [PW-1:0] pos_q;
  filter_e       filt_q;
  logic          first_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign row_last = LW'(pos_q) >= len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      filt_q  <= FILT_NONE;
      first_q <= 1'b1;
    end else if (in_acc) begin
      if (pos_q == '0) begin
        // Unknown filter types fall back to None.
        filt_q <= (data_byte_i <= 8'd4) ? filter_e'(data_byte_i[2:0]) : FILT_NONE;
        if (image_start_i) begin
          first_q <= 1'b1;
        end
        pos_q <= PW'(1);
      end else if (row_last) begin
        pos_q   <= '0;
        first_q <= 1'b0;
      end else begin
        pos_q <= PW'(pos_q + PW'(1));
      end
    end
  end

  // Work stage: holds the accepted beat and the above byte read for it at accept
  logic          s1_valid_q, s1_pix_q, s1_first_q, s1_last_q, s1_adv;
  logic [7:0]    s1_data_q;
  filter_e       s1_filt_q;
  logic [AW-1:0] s1_idx_q;
  logic          out_ready;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_pix_q || out_ready);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pos_q != '0;
      s1_data_q  <= data_byte_i;
      s1_filt_q  <= filt_q;
      s1_first_q <= first_q;
      s1_last_q  <= row_last;
      s1_idx_q   <= AW'(pos_q - PW'(1));
    end
  end

  // Above-row RAM: read at accept, written when the byte is reconstructed
  logic [7:0] above_mem [MAX_ROW_BYTES];
  logic [7:0] above_rd_q;
  logic [7:0] above_b, pixel_val;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_rd_q <= above_mem[AW'(pos_q - PW'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pix_q) begin
      above_mem[s1_idx_q] <= pixel_val;
    end
  end

  assign above_b = s1_first_q ? 8'd0 : above_rd_q;

  // Left and upper-left windows: shift per pixel byte, clear per filter byte
  logic [7:0] left_q [4];
  logic [7:0] upleft_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      if (s1_pix_q) begin
        for (int i = 3; i > 0; i--) begin
          left_q[i]   <= left_q[i-1];
          upleft_q[i] <= upleft_q[i-1];
        end
        left_q[0]   <= pixel_val;
        upleft_q[0] <= above_b;
      end else begin
        for (int i = 0; i < 4; i++) begin
          left_q[i]   <= 8'd0;
          upleft_q[i] <= 8'd0;
        end
      end
    end
  end

  pngu_predict u_predict (
    .filt_i   (s1_filt_q),
    .left_i   (left_q[dist_sel]),
    .above_i  (above_b),
    .upleft_i (upleft_q[dist_sel]),
    .data_i   (s1_data_q),
    .pixel_o  (pixel_val)
  );

  // Output register
  logic out_load, out_valid_q;
  logic [7:0] pixel_q;
  logic row_end_q;

  assign out_load = s1_adv && s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_q   <= pixel_val;
      row_end_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_end_o    = row_end_q;

  `ASSERT_CLK(a_stall_needs_beat, in_stall_o |-> (s1_valid_q && s1_pix_q), "stall without a held pixel beat")
  `ASSERT_CLK(a_filter_beat_tag, (in_acc && pos_q == '0) |=> !s1_pix_q, "filter beat tagged as pixel")
  `ASSERT_NEVER(a_filter_never_stalls, s1_valid_q && !s1_pix_q && in_stall_o, "filter beat blocked input")

endmodule

// ----- dv/tb.sv -----
// Testbench for png_scanline_unfilter: random and directed scanline streams
// checked beat by beat against an in-bench row unfilter predictor.
// Depends on pngu_pkg and the png_scanline_unfilter RTL.
`timescale 1ns / 1ps

module tb;
  import pngu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_BYTES = 820;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } pixel_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_BYTES_PER_ROW;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = '0;
  logic             image_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       pixel_byte_o;
  logic             row_end_o;

  png_scanline_unfilter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .image_start_i (image_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state, mirrors the block after reset.
  logic [12:0] row_reg = 13'd1;
  logic [2:0]  pix_reg = 3'd1;
  logic [7:0]  above_mem [0:DEF_MAX_ROW_BYTES-1];
  logic [7:0]  left_win [0:3] = '{default: 8'd0};
  logic [7:0]  upleft_win [0:3] = '{default: 8'd0};
  int          row_pos = 0;
  filter_e     cur_filter = FILT_NONE;
  bit          top_row = 1'b1;
  int          above_extent = 0;

  pixel_beat_t pixel_q [$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;
  int          byte_mode = 0;
  int          stall_run = 0;
  bit          stall_on = 1'b0;

  function automatic int row_len();
    if (row_reg == 0) return 1;
    if (row_reg > DEF_MAX_ROW_BYTES) return DEF_MAX_ROW_BYTES;
    return int'(row_reg);
  endfunction

  function automatic int pix_dist();
    if (pix_reg == 0) return 1;
    if (pix_reg > 4) return 4;
    return int'(pix_reg);
  endfunction

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int ia, ib, ic, pa, pb, pc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    pa = (ib > ic) ? ib - ic : ic - ib;
    pb = (ia > ic) ? ia - ic : ic - ia;
    pc = (ia + ib > 2 * ic) ? ia + ib - 2 * ic : 2 * ic - ia - ib;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advance the predictor by one accepted byte; queue the pixel it yields.
  task automatic unfilter_byte(input logic [7:0] d, input bit s);
    int          len, px_gap, idx, k;
    logic [7:0]  a, b, c, p;
    pixel_beat_t beat;
    len    = row_len();
    px_gap = pix_dist();
    if (row_pos == 0) begin
      cur_filter = (d <= 4) ? filter_e'(d[2:0]) : FILT_NONE;
      if (s) top_row = 1'b1;
      for (k = 0; k < 4; k++) begin
        left_win[k]   = 8'd0;
        upleft_win[k] = 8'd0;
      end
      row_pos = 1;
    end else begin
      idx = row_pos - 1;
      a = left_win[px_gap-1];
      b = top_row ? 8'd0 : above_mem[idx];
      c = upleft_win[px_gap-1];
      case (cur_filter)
        FILT_SUB:   p = a;
        FILT_UP:    p = b;
        FILT_AVG:   p = 8'((int'(a) + int'(b)) >> 1);
        FILT_PAETH: p = paeth_pick(a, b, c);
        default:    p = 8'd0;
      endcase
      beat.pixel = d + p;
      for (k = 3; k > 0; k--) begin
        left_win[k]   = left_win[k-1];
        upleft_win[k] = upleft_win[k-1];
      end
      left_win[0]    = beat.pixel;
      upleft_win[0]  = b;
      above_mem[idx] = beat.pixel;
      if (idx + 1 > above_extent) above_extent = idx + 1;
      beat.row_end = (row_pos >= len);
      if (beat.row_end) begin
        row_pos = 0;
        top_row = 1'b0;
      end else begin
        row_pos++;
      end
      pixel_q.push_back(beat);
    end
  endtask

  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 16);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [0:5] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
    case (byte_mode)
      1:       return edges[$urandom_range(0, 5)];
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 99) < 88) return 8'($urandom_range(0, 4));
    return 8'($urandom_range(5, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 20) return 13'd1;
    if (r < 70) return 13'($urandom_range(2, 16));
    if (r < 92) return 13'($urandom_range(17, 48));
    return 13'($urandom_range(49, 160));
  endfunction

  // Send one beat; returns right after the edge that took it. Valid stays high.
  task automatic send_byte(input logic [7:0] d, input bit s);
    int gap;
    bit taken;
    gap = 0;
    if (!steady && $urandom_range(0, 99) >= 55) gap = pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= d;
    image_start_i <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    bytes_sent++;
    unfilter_byte(d, s);
  endtask

  // Drop valid, drain all pending pixels and let the pipeline go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] row_val, input logic [CFG_W-1:0] pix_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_BYTES_PER_ROW;
    cfg_wdata_i <= row_val;
    @(posedge clk_i);
    row_reg = row_val;
    cfg_idx_i   <= REG_BYTES_PER_PIXEL;
    cfg_wdata_i <= pix_val;
    @(posedge clk_i);
    pix_reg = pix_val[2:0];
    cfg_we_i <= 1'b0;
  endtask

  // Filter byte plus one full row; force image start when the row above
  // would reach entries never written.
  task automatic send_row(input logic [7:0] filt, input bit want_start);
    int len;
    bit s;
    len = row_len();
    s = want_start || (!top_row && len > above_extent);
    send_byte(filt, s);
    repeat (len) send_byte(pick_byte(), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_reset_defaults();
    // One-byte rows and one-byte pixel distance straight out of reset.
    send_byte(8'(FILT_NONE), 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'(FILT_UP), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_filter_kinds();
    settle();
    configure(13'd4, 13'd2);
    send_byte(8'(FILT_PAETH), 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'(FILT_AVG), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'(FILT_SUB), 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    // Paeth row of all-zero data bytes.
    send_byte(8'(FILT_PAETH), 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
  endtask

  task automatic test_mid_row_change();
    settle();
    configure(13'd8, 13'd1);
    byte_mode = 0;
    send_byte(8'(FILT_SUB), 1'b1);
    repeat (5) send_byte(pick_byte(), 1'b0);
    // Shrink the row below the current position: next byte closes it.
    settle();
    configure(13'd3, 13'd4);
    send_byte(8'h10, 1'b0);
    send_row(8'(FILT_PAETH), 1'b0);
    settle();
    configure(13'd6, 13'd2);
    send_byte(8'(FILT_AVG), 1'b0);
    repeat (2) send_byte(pick_byte(), 1'b0);
    // Widen the pixel distance mid-row; windows keep their bytes.
    settle();
    configure(13'd6, 13'd3);
    repeat (4) send_byte(pick_byte(), 1'b0);
  endtask

  task automatic test_random_stream();
    int target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      settle();
      steady = ($urandom_range(0, 4) == 0);
      configure(pick_len(), {10'($urandom), 3'($urandom_range(0, 7))});
      repeat ($urandom_range(1, 6)) begin
        byte_mode = $urandom_range(0, 2);
        send_row(pick_filter(), $urandom_range(0, 7) == 0);
      end
    end
    settle();
    steady = 1'b0;
  endtask

  task automatic test_register_extremes();
    settle();
    configure(13'd0, 13'd0);
    repeat (3) send_row(pick_filter(), 1'b0);
    // Oversized length and distance; close the row early by shrinking it.
    settle();
    configure(13'h1fff, 13'd7);
    byte_mode = 0;
    send_byte(8'(FILT_PAETH), 1'b1);
    repeat (20) send_byte(pick_byte(), 1'b0);
    settle();
    configure(13'd8, 13'd7);
    send_byte(pick_byte(), 1'b0);
    settle();
    configure(13'd4096, 13'd4);
    byte_mode = 2;
    send_byte(8'(FILT_AVG), 1'b0);
    repeat (20) send_byte(pick_byte(), 1'b0);
    settle();
    configure(13'd20, 13'd4);
    send_byte(pick_byte(), 1'b0);
    settle();
    configure(13'd1, 13'd1);
    repeat (2) send_row(8'(FILT_UP), 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_filter_kinds();
    test_mid_row_change();
    test_random_stream();
    test_register_extremes();
    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Random output stall: mostly short runs, a few long ones.
  always @(posedge clk_i) begin
    if (steady) begin
      stall_run = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on  = ($urandom_range(0, 99) < 35);
        stall_run = stall_on ? pause_len() : $urandom_range(1, 12);
      end
      stall_run--;
      out_stall_i <= stall_on;
    end
  end

  // Outputs and stall are stable by the falling edge; a beat seen here is
  // taken at the next rising edge.
  always @(negedge clk_i) begin : check_beats
    pixel_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual pixel_byte %h row_end %b",
                 $time, pixel_byte_o, row_end_o);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_byte_o !== want.pixel) begin
          $display("%0t: pixel_byte expected %h actual %h", $time, want.pixel, pixel_byte_o);
          fail_count++;
        end
        if (row_end_o !== want.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time, want.row_end, row_end_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, expected %0d more beats", $time, pixel_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ----- png_scanline_unfilter.f -----
+incdir+design
design/pngu_pkg.sv
design/pngu_predict.sv
design/png_scanline_unfilter.sv
dv/tb.sv
